FILE: hw/rtl/imu_df_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_df_pkg
// Shared types and constants for the frame deframer.
// ----------------------------------------------------------------------------
package imu_df_pkg;

  localparam logic [7:0]  PREAMBLE     = 8'hFA;
  localparam logic [7:0]  BUS_MASTER   = 8'hFF;
  localparam logic [7:0]  BUS_ONE      = 8'h01;
  localparam logic [7:0]  EXT_LEN_MARK = 8'hFF;
  localparam logic [15:0] MAX_LEN      = 16'd2048;

  // event queue between parser and output side
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_GOOD    = 2'd1,
    EV_CRC     = 2'd2,
    EV_LEN     = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    ST_HUNT = 3'd0,
    ST_BUS  = 3'd1,
    ST_ID   = 3'd2,
    ST_LEN  = 3'd3,
    ST_XHI  = 3'd4,
    ST_XLO  = 3'd5,
    ST_BODY = 3'd6
  } stage_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  message_id;
    logic [7:0]  payload_byte;
    logic [10:0] byte_index;
    logic [15:0] frame_length;
    logic        last;
  } ev_rec_t;

endpackage
`default_nettype wire

FILE: hw/rtl/imu_df_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_df_parser
// Front end: frame state machine, one byte per beat, pushes event records.
// ----------------------------------------------------------------------------
module imu_df_parser (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   byte_vld,
  input  wire  [7:0]            rx_byte,
  input  wire                   q_full,
  output logic                  push,
  output imu_df_pkg::ev_rec_t   rec
);
  import imu_df_pkg::*;

  stage_t      stage_r, stage_nxt;
  logic [7:0]  sum_r,   sum_nxt;
  logic [7:0]  id_r,    id_nxt;
  logic [15:0] len_r,   len_nxt;
  logic [15:0] rem_r,   rem_nxt;
  logic [10:0] pos_r,   pos_nxt;
  logic [15:0] xlen;
  logic        byte_take;

  assign byte_take = byte_vld && !q_full;
  assign xlen      = {len_r[15:8], rx_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_HUNT;
      sum_r   <= '0;
      id_r    <= '0;
      len_r   <= '0;
      rem_r   <= '0;
      pos_r   <= '0;
    end else begin
      stage_r <= stage_nxt;
      sum_r   <= sum_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_comb begin
    stage_nxt = stage_r;
    sum_nxt   = sum_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    push      = 1'b0;
    rec       = '0;
    rec.message_id   = id_r;
    rec.frame_length = len_r;
    if (byte_take) begin
      sum_nxt = sum_r + rx_byte;
      unique case (stage_r)
        ST_BUS: begin
          stage_nxt = (rx_byte == BUS_MASTER || rx_byte == BUS_ONE) ? ST_ID : ST_HUNT;
        end
        ST_ID: begin
          id_nxt    = rx_byte;
          stage_nxt = ST_LEN;
        end
        ST_LEN: begin
          len_nxt   = {8'd0, rx_byte};
          rem_nxt   = {8'd0, rx_byte};
          pos_nxt   = '0;
          stage_nxt = (rx_byte == EXT_LEN_MARK) ? ST_XHI : ST_BODY;
        end
        ST_XHI: begin
          len_nxt   = {rx_byte, 8'd0};
          stage_nxt = ST_XLO;
        end
        ST_XLO: begin
          len_nxt = xlen;
          if (xlen > MAX_LEN) begin
            stage_nxt        = ST_HUNT;
            push             = 1'b1;
            rec.event_res    = EV_LEN;
            rec.frame_length = xlen;
            rec.last         = 1'b1;
          end else begin
            rem_nxt   = xlen;
            pos_nxt   = '0;
            stage_nxt = ST_BODY;
          end
        end
        ST_BODY: begin
          push = 1'b1;
          if (rem_r != '0) begin
            rem_nxt          = rem_r - 16'd1;
            pos_nxt          = pos_r + 11'd1;
            rec.event_res    = EV_PAYLOAD;
            rec.payload_byte = rx_byte;
            rec.byte_index   = pos_r;
          end else begin
            stage_nxt     = ST_HUNT;
            rec.event_res = (sum_nxt == 8'd0) ? EV_GOOD : EV_CRC;
            rec.last      = 1'b1;
          end
        end
        default: begin
          // hunting (and the unused stage code)
          stage_nxt = (rx_byte == PREAMBLE) ? ST_BUS : ST_HUNT;
          sum_nxt   = '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/imu_df_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_df_queue
// Back end: short event queue whose head drives the result channel.
// ----------------------------------------------------------------------------
module imu_df_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  imu_df_pkg::ev_rec_t   push_rec,
  output logic                  full,
  output logic                  head_vld,
  input  wire                   head_stall,
  output imu_df_pkg::ev_rec_t   head_rec
);
  import imu_df_pkg::*;

  ev_rec_t        mem [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full     = (cnt_r == QAW'(0) + (QAW+1)'(QDEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_rec = mem[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = head_vld && !head_stall;

  always_comb begin
    wr_nxt  = do_push ? wr_r + QAW'(1) : wr_r;
    rd_nxt  = do_pop  ? rd_r + QAW'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_rec;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/imu_frame_deframer.sv
`default_nettype none
// Output: result beats are registered in the event queue and offered from its head.
// Throughput: one byte per cycle; in_stall rises only when the 4-entry event
// queue is full, so a stalled output side blocks input after four results.
// Reset: synchronous, active-low rst_n returns the parser to preamble hunting
// and empties the queue; queue storage itself is not cleared.
// ----------------------------------------------------------------------------
// imu_frame_deframer
// Length-prefixed frame parser with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
module imu_frame_deframer (
  input  wire         clk,
  input  wire         rst_n,
  // input channel: one received serial byte per beat
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_rx_byte,
  // result channel: payload bytes and frame status
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_message_id,
  output logic [7:0]  out_payload_byte,
  output logic [10:0] out_byte_index,
  output logic [15:0] out_frame_length,
  output logic        out_last
);
  import imu_df_pkg::*;

  logic    q_full;
  logic    push;
  ev_rec_t rec;
  ev_rec_t head;

  // front end parses every accepted beat; it waits only on queue space
  imu_df_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (in_valid),
    .rx_byte   (in_rx_byte),
    .q_full    (q_full),
    .push      (push),
    .rec       (rec)
  );

  // back end: queue head is the result beat; drains independently
  imu_df_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (rec),
    .full       (q_full),
    .head_vld   (out_valid),
    .head_stall (out_stall),
    .head_rec   (head)
  );

  // parser takes a beat whenever in_valid is high and the queue has room
  assign in_stall = q_full;

  assign out_event_res    = head.event_res;
  assign out_message_id   = head.message_id;
  assign out_payload_byte = head.payload_byte;
  assign out_byte_index   = head.byte_index;
  assign out_frame_length = head.frame_length;
  assign out_last         = head.last;

endmodule
`default_nettype wire

FILE: hw/rtl/imu_df_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_df_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module imu_df_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  out_event_res,
  input wire [7:0]  out_message_id,
  input wire [7:0]  out_payload_byte,
  input wire [10:0] out_byte_index,
  input wire [15:0] out_frame_length,
  input wire        out_last
);
  import imu_df_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_event_res) && $stable(out_byte_index)
      && $stable(out_payload_byte) && $stable(out_frame_length)
      && $stable(out_message_id) && $stable(out_last))
    else $error("stalled result beat changed");

  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_event_res != EV_PAYLOAD)))
    else $error("last flag does not match event kind");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_PAYLOAD |->
      out_payload_byte == 8'd0 && out_byte_index == 11'd0)
    else $error("status beat carries payload data");

  a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_LEN |-> out_frame_length > MAX_LEN)
    else $error("length error on an acceptable length");

endmodule

bind imu_frame_deframer imu_df_checker u_df_checker (.*);
`default_nettype wire
